### rtl/core/piecewise_linear_current_calibration_macros.svh
`ifndef PIECEWISE_LINEAR_CURRENT_CALIBRATION_MACROS_SVH
`define PIECEWISE_LINEAR_CURRENT_CALIBRATION_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLCC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plcc assertion failed");

// next-cycle implication, disabled during reset
`define PLCC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plcc assertion failed");

`endif

### rtl/core/plcc_pkg.sv
package plcc_pkg;

    localparam int DEF_MAX_POINTS    = 16;
    localparam int DEF_CURRENT_WIDTH = 24;

    localparam int GAIN_W    = 20;
    localparam int FRAC_BITS = 16;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 20'sd65536;

    typedef enum logic [0:0] {
        OP_CONVERT = 1'b0,
        OP_WRITE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SRC_LINEAR   = 2'd0,
        SRC_INTERP   = 2'd1,
        SRC_CLAMP_LO = 2'd2,
        SRC_CLAMP_HI = 2'd3
    } src_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LIN_MAG,
        DP_MUL,
        DP_LIN_RND,
        DP_LIN_ADD,
        DP_TAKE_RD,
        DP_HOLD_HI,
        DP_DIFF,
        DP_TAKE_Y0,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        src_t   src;
        logic   capture;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic               raw_le_rd;
        logic               raw_ge_rd;
        logic               dx_zero;
        logic               div_ovf;
        logic [COUNT_W-1:0] point_count;
    } dp_stat_t;

endpackage

### rtl/core/plcc_datapath.sv
module plcc_datapath import plcc_pkg::*; #(
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int CURRENT_WIDTH = DEF_CURRENT_WIDTH,
    localparam int ADDR_W = $clog2(MAX_POINTS),
    localparam int CFG_W  = (CURRENT_WIDTH > GAIN_W) ? CURRENT_WIDTH : GAIN_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  logic                            s_op,
    input  logic [INDEX_W-1:0]              s_point_index,
    input  logic signed [CURRENT_WIDTH-1:0] s_raw_current,
    input  logic signed [CURRENT_WIDTH-1:0] s_true_current,
    input  dp_cmd_t                         cmd,
    input  logic [ADDR_W-1:0]               rd_addr,
    output dp_stat_t                        stat,
    output logic signed [CURRENT_WIDTH-1:0] m_calibrated_current,
    output logic [1:0]                      m_source,
    output logic                            m_saturated
);

    localparam int CW = CURRENT_WIDTH;
    localparam int MW = (CW > GAIN_W) ? CW : GAIN_W;
    localparam int PW = 2 * MW;
    localparam int RW = PW - FRAC_BITS + 1;
    localparam int SW = RW + 2;

    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] VMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic signed [CW-1:0]     mem_raw  [MAX_POINTS];
    logic signed [CW-1:0]     mem_true [MAX_POINTS];

    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [CW-1:0]     offset_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic signed [CW-1:0]     rd_raw_reg;
    logic signed [CW-1:0]     rd_true_reg;
    logic signed [CW-1:0]     raw_reg;
    logic signed [CW-1:0]     x1_reg;
    logic signed [CW-1:0]     y1_reg;
    logic signed [CW-1:0]     y0_reg;
    logic [MW-1:0]            ma_reg;
    logic [MW-1:0]            mb_reg;
    logic [MW-1:0]            d_reg;
    logic                     neg_reg;
    logic                     dx_zero_reg;
    logic                     ovf_reg;
    logic [PW-1:0]            prod_reg;
    logic [RW-1:0]            rnd_reg;
    logic [CW-1:0]            rem_reg;
    logic [CW-1:0]            quo_reg;
    logic signed [CW-1:0]     res_val_reg;
    src_t                     res_src_reg;
    logic                     res_sat_reg;
    logic signed [CW-1:0]     out_val_reg;
    src_t                     out_src_reg;
    logic                     out_sat_reg;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [MW:0]       raw_x;
    logic signed [MW:0]       rd_raw_x;
    logic signed [MW:0]       rd_true_x;
    logic signed [MW:0]       x1_x;
    logic signed [MW:0]       y1_x;
    logic signed [MW:0]       gain_x;
    logic signed [MW:0]       dxr;
    logic signed [MW:0]       dy;
    logic signed [MW:0]       dx;
    logic [MW-1:0]            raw_mag;
    logic [MW-1:0]            gain_mag;
    logic [MW-1:0]            dxr_mag;
    logic [MW-1:0]            dy_mag;
    logic [MW-1:0]            dx_mag;
    logic [PW:0]              rnd_sum;
    logic signed [SW-1:0]     lin_acc;
    logic signed [SW-1:0]     fin_acc;
    logic [CW:0]              lin_clip;
    logic [CW:0]              fin_clip;
    logic [CW:0]              div_rs;
    logic [CW:0]              div_diff;
    logic                     div_ge;
    logic [CW-1:0]            rem_next;

    function automatic logic [MW-1:0] mag(input logic signed [MW:0] v);
        logic [MW:0] a;
        a = v[MW] ? $unsigned(-v) : $unsigned(v);
        return a[MW-1:0];
    endfunction

    function automatic logic [CW:0] clip_fn(input logic signed [SW-1:0] v);
        logic [CW:0] r;
        if (v > VMAX) begin
            r = {1'b1, VMAX[CW-1:0]};
        end else if (v < VMIN) begin
            r = {1'b1, VMIN[CW-1:0]};
        end else begin
            r = {1'b0, v[CW-1:0]};
        end
        return r;
    endfunction

    // calibration table
    assign wr_en   = cmd.capture && (s_op == OP_WRITE) && (int'(s_point_index) < MAX_POINTS);
    assign wr_addr = ADDR_W'(s_point_index);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_raw[wr_addr]  <= s_raw_current;
            mem_true[wr_addr] <= s_true_current;
        end
        rd_raw_reg  <= mem_raw[rd_addr];
        rd_true_reg <= mem_true[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= '0;
            count_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_data[CW-1:0];
                CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        raw_x     = (MW+1)'(raw_reg);
        rd_raw_x  = (MW+1)'(rd_raw_reg);
        rd_true_x = (MW+1)'(rd_true_reg);
        x1_x      = (MW+1)'(x1_reg);
        y1_x      = (MW+1)'(y1_reg);
        gain_x    = (MW+1)'(gain_reg);
        dxr       = raw_x - rd_raw_x;
        dy        = y1_x - rd_true_x;
        dx        = x1_x - rd_raw_x;
        raw_mag   = mag(raw_x);
        gain_mag  = mag(gain_x);
        dxr_mag   = mag(dxr);
        dy_mag    = mag(dy);
        dx_mag    = mag(dx);

        rnd_sum   = {1'b0, prod_reg} + HALF;
        lin_acc   = neg_reg ? SW'(offset_reg) - $signed({2'b00, rnd_reg})
                            : SW'(offset_reg) + $signed({2'b00, rnd_reg});
        fin_acc   = neg_reg ? SW'(y0_reg) - $signed({{(SW-CW){1'b0}}, quo_reg})
                            : SW'(y0_reg) + $signed({{(SW-CW){1'b0}}, quo_reg});
        lin_clip  = clip_fn(lin_acc);
        fin_clip  = clip_fn(fin_acc);

        // restoring divide, one quotient bit per step
        div_rs    = {rem_reg, quo_reg[CW-1]};
        div_ge    = div_rs >= {1'b0, d_reg[CW-1:0]};
        div_diff  = div_rs - {1'b0, d_reg[CW-1:0]};
        rem_next  = div_ge ? div_diff[CW-1:0] : div_rs[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg <= s_raw_current;
        end
        case (cmd.op)
            DP_LIN_MAG: begin
                ma_reg  <= raw_mag;
                mb_reg  <= gain_mag;
                neg_reg <= raw_reg[CW-1] ^ gain_reg[GAIN_W-1];
            end
            DP_MUL: begin
                prod_reg <= ma_reg * mb_reg;
            end
            DP_LIN_RND: begin
                rnd_reg <= rnd_sum[PW:FRAC_BITS];
            end
            DP_LIN_ADD: begin
                res_sat_reg <= lin_clip[CW];
                res_val_reg <= lin_clip[CW-1:0];
                res_src_reg <= cmd.src;
            end
            DP_TAKE_RD: begin
                res_sat_reg <= 1'b0;
                res_val_reg <= rd_true_reg;
                res_src_reg <= cmd.src;
            end
            DP_HOLD_HI: begin
                x1_reg <= rd_raw_reg;
                y1_reg <= rd_true_reg;
            end
            DP_DIFF: begin
                ma_reg      <= dxr_mag;
                mb_reg      <= dy_mag;
                d_reg       <= dx_mag;
                y0_reg      <= rd_true_reg;
                neg_reg     <= dxr[MW] ^ dy[MW] ^ dx[MW];
                dx_zero_reg <= (dx == '0);
            end
            DP_TAKE_Y0: begin
                res_sat_reg <= 1'b0;
                res_val_reg <= y0_reg;
                res_src_reg <= cmd.src;
            end
            DP_DIV_INIT: begin
                rem_reg <= prod_reg[2*CW-1:CW];
                quo_reg <= prod_reg[CW-1:0];
                ovf_reg <= prod_reg[2*CW-1:CW] >= d_reg[CW-1:0];
            end
            DP_DIV_STEP: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[CW-2:0], div_ge};
            end
            DP_FINISH: begin
                res_src_reg <= cmd.src;
                if (ovf_reg) begin
                    res_sat_reg <= 1'b1;
                    res_val_reg <= neg_reg ? VMIN[CW-1:0] : VMAX[CW-1:0];
                end else begin
                    res_sat_reg <= fin_clip[CW];
                    res_val_reg <= fin_clip[CW-1:0];
                end
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            out_val_reg <= res_val_reg;
            out_src_reg <= res_src_reg;
            out_sat_reg <= res_sat_reg;
        end
    end

    assign stat.raw_le_rd   = raw_reg <= rd_raw_reg;
    assign stat.raw_ge_rd   = raw_reg >= rd_raw_reg;
    assign stat.dx_zero     = dx_zero_reg;
    assign stat.div_ovf     = ovf_reg;
    assign stat.point_count = count_reg;

    assign m_calibrated_current = out_val_reg;
    assign m_source             = out_src_reg;
    assign m_saturated          = out_sat_reg;

endmodule

### rtl/core/plcc_ctrl.sv
module plcc_ctrl import plcc_pkg::*; #(
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int CURRENT_WIDTH = DEF_CURRENT_WIDTH,
    localparam int ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    output logic              m_valid,
    input  logic              m_ready,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd,
    output logic [ADDR_W-1:0] rd_addr
);

    localparam int CNT_W = $clog2(CURRENT_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIN_MAG,
        S_LIN_MUL,
        S_LIN_RND,
        S_LIN_ADD,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SEARCH,
        S_DIFF,
        S_INT_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FINISH,
        S_PUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] last_idx;
    logic              out_free;
    int                n_lim;

    always_comb begin
        n_lim    = (int'(stat.point_count) > MAX_POINTS) ? MAX_POINTS : int'(stat.point_count);
        last_idx = ADDR_W'(n_lim - 1);
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = DP_NOP;
        cmd.src      = SRC_LINEAR;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        rd_addr      = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_op == OP_CONVERT) begin
                        state_next = (stat.point_count == '0) ? S_LIN_MAG : S_CHK_FIRST;
                    end
                end
            end
            S_LIN_MAG: begin
                cmd.op     = DP_LIN_MAG;
                state_next = S_LIN_MUL;
            end
            S_LIN_MUL: begin
                cmd.op     = DP_MUL;
                state_next = S_LIN_RND;
            end
            S_LIN_RND: begin
                cmd.op     = DP_LIN_RND;
                state_next = S_LIN_ADD;
            end
            S_LIN_ADD: begin
                cmd.op     = DP_LIN_ADD;
                cmd.src    = SRC_LINEAR;
                state_next = S_PUSH;
            end
            S_CHK_FIRST: begin
                if (stat.raw_le_rd) begin
                    cmd.op     = DP_TAKE_RD;
                    cmd.src    = SRC_CLAMP_LO;
                    state_next = S_PUSH;
                end else begin
                    rd_addr    = last_idx;
                    state_next = S_CHK_LAST;
                end
            end
            S_CHK_LAST: begin
                if (stat.raw_ge_rd) begin
                    cmd.op     = DP_TAKE_RD;
                    cmd.src    = SRC_CLAMP_HI;
                    state_next = S_PUSH;
                end else begin
                    idx_next   = ADDR_W'(1);
                    rd_addr    = ADDR_W'(1);
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if ((idx_reg < last_idx) && stat.raw_ge_rd) begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end else begin
                    cmd.op     = DP_HOLD_HI;
                    rd_addr    = idx_reg - 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.op     = DP_DIFF;
                state_next = S_INT_MUL;
            end
            S_INT_MUL: begin
                if (stat.dx_zero) begin
                    cmd.op     = DP_TAKE_Y0;
                    cmd.src    = SRC_INTERP;
                    state_next = S_PUSH;
                end else begin
                    cmd.op     = DP_MUL;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                cmd.op     = DP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_ovf) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.op   = DP_DIV_STEP;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CURRENT_WIDTH - 1)) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                cmd.op     = DP_FINISH;
                cmd.src    = SRC_INTERP;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/core/piecewise_linear_current_calibration.sv
// Current calibration by a piecewise-linear table, with a gain/offset fallback.
// Input channel s_*: op convert takes raw_current and returns one beat on m_*;
// op write stores (raw_current, true_current) at point_index and returns nothing.
// Points must be written in ascending raw order before point_count enables them.
// Config channel cfg_*: index 0 gain (Q4.16), 1 offset, 2 point_count; always ready,
// written by the user only while no conversion is in flight; the core does not enforce it.
// One item is worked on at a time; s_ready is high only while the core is idle.
// A write beat is stored as it is accepted and the core stays idle. A conversion
// runs in linear mode (point_count zero), clamped low / clamped high, or
// interpolated in a segment, which walks the table by a linear search
// (one entry a cycle) and then runs the serial divider (one quotient bit a cycle).
// The next item is taken the cycle after a result is loaded.
// The result sits in an output register; the next item is accepted while it waits,
// and that item stalls in its last step until the receiver takes the first result.
// Synchronous active-low reset clears control, restores gain 1.0, offset 0 and
// point_count 0; table contents are undefined until written.
module piecewise_linear_current_calibration import plcc_pkg::*; #(
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int CURRENT_WIDTH = DEF_CURRENT_WIDTH,
    localparam int ADDR_W = $clog2(MAX_POINTS),
    localparam int CFG_W  = (CURRENT_WIDTH > GAIN_W) ? CURRENT_WIDTH : GAIN_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [INDEX_W-1:0]              s_point_index,
    input  logic signed [CURRENT_WIDTH-1:0] s_raw_current,
    input  logic signed [CURRENT_WIDTH-1:0] s_true_current,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [CURRENT_WIDTH-1:0] m_calibrated_current,
    output logic [1:0]                      m_source,
    output logic                            m_saturated
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] rd_addr;

    assign cfg_ready = 1'b1;

    plcc_ctrl #(
        .MAX_POINTS    (MAX_POINTS),
        .CURRENT_WIDTH (CURRENT_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    plcc_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .CURRENT_WIDTH (CURRENT_WIDTH)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_valid & cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_op                 (s_op),
        .s_point_index        (s_point_index),
        .s_raw_current        (s_raw_current),
        .s_true_current       (s_true_current),
        .cmd                  (cmd),
        .rd_addr              (rd_addr),
        .stat                 (stat),
        .m_calibrated_current (m_calibrated_current),
        .m_source             (m_source),
        .m_saturated          (m_saturated)
    );

endmodule

### rtl/core/plcc_checker.sv
`include "piecewise_linear_current_calibration_macros.svh"

module plcc_checker import plcc_pkg::*; #(
    parameter int CURRENT_WIDTH = DEF_CURRENT_WIDTH
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_op,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [CURRENT_WIDTH-1:0] m_calibrated_current,
    input logic [1:0]               m_source,
    input logic                     m_saturated
);

    // a stalled result beat holds
    `PLCC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_calibrated_current) && $stable(m_source) && $stable(m_saturated))

    // a conversion keeps the input closed on the next cycle
    `PLCC_ASSERT_NXT(a_convert_busy, aclk, aresetn, s_valid && s_ready && s_op == OP_CONVERT, !s_ready)

    // a table write produces no result beat
    `PLCC_ASSERT_NXT(a_write_silent, aclk, aresetn, s_valid && s_ready && s_op == OP_WRITE && !m_valid, !m_valid)

    // clamped results never report saturation
    `PLCC_ASSERT_IMP(a_clamp_unsat, aclk, aresetn, m_valid && (m_source == SRC_CLAMP_LO || m_source == SRC_CLAMP_HI), !m_saturated)

endmodule

bind piecewise_linear_current_calibration plcc_checker #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
) u_plcc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_op                 (s_op),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_calibrated_current (m_calibrated_current),
    .m_source             (m_source),
    .m_saturated          (m_saturated)
);

### tb/calibration_checker.sv
module calibration_checker import plcc_pkg::*; (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [DEF_CURRENT_WIDTH-1:0]        cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_op,
    input  logic [INDEX_W-1:0]                  s_point_index,
    input  logic signed [DEF_CURRENT_WIDTH-1:0] s_raw_current,
    input  logic signed [DEF_CURRENT_WIDTH-1:0] s_true_current,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [DEF_CURRENT_WIDTH-1:0] m_calibrated_current,
    input  logic [1:0]                          m_source,
    input  logic                                m_saturated,
    output int unsigned                         mismatches,
    output int unsigned                         outstanding
);

    localparam int CW  = DEF_CURRENT_WIDTH;
    localparam int PTS = DEF_MAX_POINTS;
    localparam longint CUR_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CUR_MIN = -CUR_MAX - 1;

    typedef struct packed {
        logic signed [CW-1:0] current;
        src_t                 src;
        logic                 saturated;
    } reading_t;

    logic signed [GAIN_W-1:0] gain_q;
    logic signed [CW-1:0]     offset_q;
    logic [COUNT_W-1:0]       count_q;
    logic signed [CW-1:0]     cal_raw [PTS];
    logic signed [CW-1:0]     cal_true [PTS];
    reading_t                 expected_readings [$];
    int unsigned              errs = 0;

    assign mismatches = errs;

    function automatic void enqueue_reading(input reading_t r);
        expected_readings = {expected_readings, r};
    endfunction

    function automatic reading_t calibrate_sample(logic signed [CW-1:0] sample);
        reading_t r;
        int       n;
        int       seg;
        longint   prod;
        longint   mag;
        longint   rounded;
        longint   val;
        longint   dx;
        r = '0;
        n = (count_q > PTS) ? PTS : int'(count_q);
        if (n == 0) begin
            prod = longint'(sample) * longint'(gain_q);
            mag = (prod < 0) ? -prod : prod;
            rounded = (mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            val = ((prod < 0) ? -rounded : rounded) + longint'(offset_q);
            r.src = SRC_LINEAR;
        end else if (sample <= cal_raw[0]) begin
            val = longint'(cal_true[0]);
            r.src = SRC_CLAMP_LO;
        end else if (sample >= cal_raw[n-1]) begin
            val = longint'(cal_true[n-1]);
            r.src = SRC_CLAMP_HI;
        end else begin
            // first entry above the sample closes the segment
            seg = 1;
            while (seg < n - 1 && !(sample < cal_raw[seg]))
                seg++;
            dx = longint'(cal_raw[seg]) - longint'(cal_raw[seg-1]);
            val = longint'(cal_true[seg-1]);
            if (dx != 0) begin
                val = val + (longint'(sample) - longint'(cal_raw[seg-1]))
                          * (longint'(cal_true[seg]) - longint'(cal_true[seg-1])) / dx;
            end
            r.src = SRC_INTERP;
        end
        if (val > CUR_MAX) begin
            val = CUR_MAX;
            r.saturated = 1'b1;
        end else if (val < CUR_MIN) begin
            val = CUR_MIN;
            r.saturated = 1'b1;
        end
        r.current = val[CW-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            gain_q = GAIN_RESET;
            offset_q = '0;
            count_q = '0;
            for (int k = 0; k < PTS; k++) begin
                cal_raw[k] = '0;
                cal_true[k] = '0;
            end
            expected_readings.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAIN:   gain_q = cfg_data[GAIN_W-1:0];
                    CFG_OFFSET: offset_q = cfg_data[CW-1:0];
                    CFG_COUNT:  count_q = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    errs++;
                    $display("%0t: result beat with nothing expected, current %0d",
                             $time, m_calibrated_current);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_calibrated_current !== want.current) begin
                        errs++;
                        $display("%0t: calibrated_current expected %0d actual %0d",
                                 $time, $signed(want.current), m_calibrated_current);
                    end
                    if (m_source !== want.src) begin
                        errs++;
                        $display("%0t: source expected %0d actual %0d",
                                 $time, want.src, m_source);
                    end
                    if (m_saturated !== want.saturated) begin
                        errs++;
                        $display("%0t: saturated expected %0d actual %0d",
                                 $time, want.saturated, m_saturated);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (op_t'(s_op) == OP_WRITE) begin
                    cal_raw[s_point_index] = s_raw_current;
                    cal_true[s_point_index] = s_true_current;
                end else begin
                    enqueue_reading(calibrate_sample(s_raw_current));
                end
            end
            outstanding <= expected_readings.size();
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    import plcc_pkg::*;

    localparam int CW             = DEF_CURRENT_WIDTH;
    localparam int PTS            = DEF_MAX_POINTS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RANDOM_ITEMS   = 1500;
    localparam longint CUR_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CUR_MIN = -CUR_MAX - 1;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CW-1:0]           cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_op = 1'b0;
    logic [INDEX_W-1:0]      s_point_index = '0;
    logic signed [CW-1:0]    s_raw_current = '0;
    logic signed [CW-1:0]    s_true_current = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [CW-1:0]    m_calibrated_current;
    logic [1:0]              m_source;
    logic                    m_saturated;

    int unsigned             cal_mismatches;
    int unsigned             cal_outstanding;

    bit                      steady = 1'b0;
    int                      idle_cycles = 0;
    int                      item_count = 0;
    int                      samples_sent = 0;
    int                      points_written = 0;
    int                      settings_written = 0;
    int                      phase = 0;
    logic signed [CW-1:0]    aim_raw [PTS];

    piecewise_linear_current_calibration dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_point_index        (s_point_index),
        .s_raw_current        (s_raw_current),
        .s_true_current       (s_true_current),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_calibrated_current (m_calibrated_current),
        .m_source             (m_source),
        .m_saturated          (m_saturated)
    );

    calibration_checker cal_check (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_point_index        (s_point_index),
        .s_raw_current        (s_raw_current),
        .s_true_current       (s_true_current),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_calibrated_current (m_calibrated_current),
        .m_source             (m_source),
        .m_saturated          (m_saturated),
        .mismatches           (cal_mismatches),
        .outstanding          (cal_outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CW-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        settings_written++;
    endtask

    // bits above each register's width carry noise
    task automatic configure(longint gain, longint offset, longint count);
        longint junk;
        junk = longint'($urandom);
        write_reg(CFG_GAIN, (gain & 'hFFFFF) | ((junk & 'hF) << GAIN_W));
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_COUNT, (count & 'h1F) | ((junk & 'h7FFFF) << COUNT_W));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(op_t op, logic [INDEX_W-1:0] idx, logic signed [CW-1:0] raw,
                             logic signed [CW-1:0] tru);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_point_index <= idx;
        s_raw_current <= raw;
        s_true_current <= tru;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        item_count++;
        if (op == OP_WRITE) begin
            points_written++;
            aim_raw[idx] = raw;
        end else begin
            samples_sent++;
        end
    endtask

    // drain every expected result, then let a write beat finish too
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cal_outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [CW-1:0] rand_current();
        case ($urandom_range(0, 6))
            0: return CW'(CUR_MIN);
            1: return CW'(CUR_MAX);
            2: return CW'(int'($urandom_range(0, 200)) - 100);
            3: return CW'(int'($urandom_range(0, 140000)) - 70000);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] pick_sample(bit table_mode);
        int     k;
        int     r;
        longint lo;
        longint hi;
        r = $urandom_range(0, 99);
        if (!table_mode || r < 12)
            return rand_current();
        k = $urandom_range(0, PTS - 2);
        if (r < 25)
            return aim_raw[k];
        if (r < 30)
            return CW'(aim_raw[k] + (($urandom_range(0, 1) == 0) ? -1 : 1));
        lo = (aim_raw[k] < aim_raw[k+1]) ? longint'(aim_raw[k]) : longint'(aim_raw[k+1]);
        hi = (aim_raw[k] < aim_raw[k+1]) ? longint'(aim_raw[k+1]) : longint'(aim_raw[k]);
        return CW'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endfunction

    task automatic load_table();
        int                   step_max;
        int                   first;
        bit                   scramble;
        bit                   narrow_true;
        longint               x;
        logic signed [CW-1:0] raws [PTS];
        logic signed [CW-1:0] trues [PTS];
        scramble = ($urandom_range(0, 4) == 0);
        narrow_true = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: step_max = 4;
            1: step_max = 300;
            2: step_max = 60000;
            default: step_max = 1000000;
        endcase
        x = CUR_MIN + longint'($urandom_range(0, 32'(CUR_MAX - CUR_MIN - PTS * step_max)));
        for (int k = 0; k < PTS; k++) begin
            x = x + longint'($urandom_range(1, step_max));
            raws[k] = x[CW-1:0];
            if (scramble)
                raws[k] = (k > 0 && $urandom_range(0, 2) == 0) ? raws[k-1] : rand_current();
            trues[k] = narrow_true ? CW'(int'($urandom_range(0, 200000)) - 100000)
                                   : rand_current();
        end
        first = $urandom_range(0, PTS - 1);
        for (int k = 0; k < PTS; k++)
            send_item(OP_WRITE, INDEX_W'((first + k) % PTS), raws[(first + k) % PTS],
                      trues[(first + k) % PTS]);
    endtask

    task automatic random_phase(bit fresh_table);
        longint gain;
        longint offset;
        longint count;
        int     items;
        case ($urandom_range(0, 7))
            0: gain = -524288;
            1: gain = 524287;
            2: gain = 0;
            3: gain = 65536;
            4: gain = 32768;
            5: gain = -32768;
            default: gain = longint'($urandom_range(0, 1048575)) - 524288;
        endcase
        case ($urandom_range(0, 5))
            0: offset = CUR_MIN;
            1: offset = CUR_MAX;
            2: offset = 0;
            3: offset = longint'(int'($urandom_range(0, 2000)) - 1000);
            default: offset = longint'($urandom_range(0, 16777215)) + CUR_MIN;
        endcase
        case ($urandom_range(0, 8))
            0, 1: count = 0;
            2: count = 1;
            3: count = 2;
            4: count = PTS;
            5: count = ($urandom_range(0, 1) == 0) ? 31 : longint'($urandom_range(17, 31));
            default: count = longint'($urandom_range(3, 15));
        endcase
        configure(gain, offset, count);
        if (fresh_table)
            load_table();
        items = $urandom_range(30, 90);
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_WRITE, INDEX_W'($urandom_range(0, PTS - 1)), pick_sample(1'b1),
                          rand_current());
            else
                send_item(OP_CONVERT, INDEX_W'($urandom_range(0, PTS - 1)),
                          pick_sample(count != 0), CW'($urandom));
        end
        settle();
    endtask

    initial begin
        int directed_items;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: unity gain, no offset, linear mode
        send_item(OP_CONVERT, 0, 0, 0);
        send_item(OP_CONVERT, 0, CW'(CUR_MAX), 0);
        send_item(OP_CONVERT, 0, CW'(CUR_MIN), 0);
        send_item(OP_CONVERT, 0, 3, 0);
        send_item(OP_CONVERT, 0, -3, 0);
        settle();

        // most negative gain against the top offset: clips both ways
        configure(-524288, CUR_MAX, 0);
        send_item(OP_CONVERT, 0, CW'(CUR_MAX), 0);
        send_item(OP_CONVERT, 0, CW'(CUR_MIN), 0);
        send_item(OP_CONVERT, 0, 1, 0);
        settle();

        // half gain on odd samples rounds ties away from zero
        configure(32768, CUR_MIN, 0);
        send_item(OP_CONVERT, 0, 3, 0);
        send_item(OP_CONVERT, 0, -3, 0);
        settle();

        send_item(OP_WRITE, 0, -1000, -2000);
        send_item(OP_WRITE, 1, 0, 50);
        send_item(OP_WRITE, 2, 1000, 3000);
        send_item(OP_WRITE, 3, 5000, -7000);
        settle();

        configure(65536, 0, 4);
        send_item(OP_CONVERT, 0, CW'(CUR_MIN), 0);
        send_item(OP_CONVERT, 0, -1000, 0);
        send_item(OP_CONVERT, 0, -333, 0);
        send_item(OP_CONVERT, 0, 999, 0);
        send_item(OP_CONVERT, 0, 1001, 0);
        send_item(OP_CONVERT, 0, 3000, 0);
        send_item(OP_CONVERT, 0, 5000, 0);
        send_item(OP_CONVERT, 0, CW'(CUR_MAX), 0);
        settle();

        // one point: its true value on either side
        configure(65536, 0, 1);
        send_item(OP_CONVERT, 0, -2000, 0);
        send_item(OP_CONVERT, 0, 2000, 0);
        settle();

        directed_items = item_count;
        while (item_count - directed_items < RANDOM_ITEMS) begin
            steady = (phase >= 6 && phase < 10);
            random_phase(phase == 0 || $urandom_range(0, 1) == 1);
            phase++;
        end
        steady = 1'b0;

        $display("converted %0d samples and loaded %0d table points over %0d register writes",
                 samples_sent, points_written, settings_written);
        $display("%0d random phases across linear, clamped and interpolated modes", phase);
        if (cal_mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### piecewise_linear_current_calibration.f
+incdir+rtl/core
rtl/core/plcc_pkg.sv
rtl/core/plcc_datapath.sv
rtl/core/plcc_ctrl.sv
rtl/core/piecewise_linear_current_calibration.sv
rtl/core/plcc_checker.sv
tb/calibration_checker.sv
tb/testbench.sv
